// ===== hdl/dto_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dto_pkg
// Shared types, codes and helpers of the dependency transition oracle.
// ----------------------------------------------------------------------------
package dto_pkg;

  localparam int MAX_WORDS = 64;
  localparam int SLOTS     = MAX_WORDS + 2;

  localparam logic [6:0] NO_PARENT = 7'd127;
  localparam logic [5:0] NO_LABEL  = 6'd63;

  // item actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_TRANS = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // transitions
  localparam logic [1:0] TR_SHIFT  = 2'd0;
  localparam logic [1:0] TR_RIGHT  = 2'd1;
  localparam logic [1:0] TR_LEFT   = 2'd2;
  localparam logic [1:0] TR_REDUCE = 2'd3;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_APPL  = 2'd1;
  localparam logic [1:0] ST_LABEL_BIG = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SYSTEM = 2'd0;
  localparam logic [1:0] CFG_ROOT   = 2'd1;
  localparam logic [1:0] CFG_LABELS = 2'd2;
  localparam logic [1:0] CFG_WORDS  = 2'd3;

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_LOAD   = 21'h000002,
    S_READ_A = 21'h000004,
    S_READ_B = 21'h000008,
    S_BEGIN  = 21'h000010,
    S_CTX_A  = 21'h000020,
    S_CTX_B  = 21'h000040,
    S_CTX_C  = 21'h000080,
    S_CTX_D  = 21'h000100,
    S_CTX_E  = 21'h000200,
    S_TRANS  = 21'h000400,
    S_FIN_A  = 21'h000800,
    S_FIN_B  = 21'h001000,
    S_FIN_C  = 21'h002000,
    S_EVAL   = 21'h004000,
    S_SCAN_A = 21'h008000,
    S_SCAN_B = 21'h010000,
    S_SCAN_C = 21'h020000,
    S_BUF_A  = 21'h040000,
    S_BUF_B  = 21'h080000,
    S_PUT    = 21'h100000
  } state_t;

  // saturating cost counter step
  function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [1:0] inc);
    logic [8:0] s;
    s = {1'b0, c} + {7'd0, inc};
    return s[8] ? 8'd255 : s[7:0];
  endfunction

  // step loss of one attachment
  function automatic logic [1:0] arc_loss(input logic [6:0] gold_hd, input logic [5:0] gold_lab,
                                          input logic [6:0] hd, input logic [5:0] lab);
    if (gold_hd != hd) return 2'd2;
    return (gold_lab != lab) ? 2'd1 : 2'd0;
  endfunction

endpackage

// ===== hdl/dependency_transition_oracle_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_transition_oracle_top
// Arc-hybrid / arc-eager parse engine with dynamic-oracle transition costs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: load gold word, begin
//   parse, apply transition or read word. Each item yields exactly one result
//   item on the out_valid/out_ready channel, held in an output register.
//   Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle;
//   the block itself does not enforce it.
// Throughput and sequencing:
//   The block works on one item at a time; in_ready is high only in idle.
//   A shared sequencer walks the stack and remaining buffer through the
//   registered memory read ports, one memory access round per step. The
//   stack walk makes 3 memory reads per entry (stack, then gold and
//   assigned head), plus the compare step.
// Reset (rst_n, synchronous, active low):
//   Configuration returns to its defaults, stack and position to zero, and
//   all assigned heads and tags read as unassigned. Gold and stack stores
//   hold nothing defined until written.
// Stall:
//   A finished item waits in the output register; the next item may be taken
//   and worked on meanwhile, and its result waits for the register to empty.
// ----------------------------------------------------------------------------
module dependency_transition_oracle_top (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [6:0] in_word,
  input  logic [6:0] in_gold_parent,
  input  logic [5:0] in_gold_label,
  input  logic [1:0] in_transition,
  input  logic [5:0] in_arc_label,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_position,
  output logic [6:0] out_depth,
  output logic [3:0] out_valid_mask,
  output logic [7:0] out_cost_shift,
  output logic [7:0] out_cost_right,
  output logic [7:0] out_cost_left,
  output logic [7:0] out_cost_reduce,
  output logic [1:0] out_step_loss,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic [6:0] out_read_parent,
  output logic [5:0] out_read_label,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam logic [6:0] SLOTS_W = 7'(dto_pkg::SLOTS);
  localparam logic [6:0] MAXW_W  = 7'(dto_pkg::MAX_WORDS);

  // ---------------- configuration ----------------
  logic       sys_r;          // 0 arc-hybrid, 1 arc-eager
  logic [5:0] root_tag_r;
  logic [5:0] label_count_r;
  logic [6:0] words_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_r         <= 1'b0;
      root_tag_r    <= 6'd8;
      label_count_r <= 6'd12;
      words_r       <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dto_pkg::CFG_SYSTEM: sys_r         <= cfg_data[0];
        dto_pkg::CFG_ROOT:   root_tag_r    <= cfg_data[5:0];
        dto_pkg::CFG_LABELS: label_count_r <= cfg_data[5:0];
        dto_pkg::CFG_WORDS:  words_r       <= cfg_data;
        default:             sys_r         <= sys_r;
      endcase
    end
  end

  logic [6:0] n, np1;
  assign n   = (words_r > MAXW_W) ? MAXW_W : words_r;
  assign np1 = n + 7'd1;

  // ---------------- control registers ----------------
  dto_pkg::state_t state_r, state_nxt;
  logic       phase_r, phase_nxt;      // 0: check before a transition, 1: evaluate
  logic [1:0] act_r, act_nxt;
  logic [6:0] word_r, word_nxt;
  logic [6:0] gpar_r, gpar_nxt;
  logic [5:0] glab_r, glab_nxt;
  logic [1:0] tr_r, tr_nxt;
  logic [5:0] alab_r, alab_nxt;
  logic [6:0] sp_r, sp_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [6:0] top_r, top_nxt;
  logic [6:0] second_r, second_nxt;
  logic [6:0] gpl_r, gpl_nxt;          // gold head of stack top
  logic [5:0] gll_r, gll_nxt;
  logic [6:0] hpl_r, hpl_nxt;          // assigned head of stack top
  logic [6:0] gpi_r, gpi_nxt;          // gold head of buffer front
  logic [5:0] gli_r, gli_nxt;
  logic [6:0] hpi_r, hpi_nxt;
  logic [6:0] s_r, s_nxt;
  logic [6:0] t_r, t_nxt;
  logic [6:0] si_r, si_nxt;
  logic [6:0] scnt_r, scnt_nxt;
  logic [6:0] bi_r, bi_nxt;
  logic [7:0] c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic [1:0] loss_r, loss_nxt;
  logic [1:0] status_r, status_nxt;
  logic [6:0] rp_r, rp_nxt;
  logic [5:0] rl_r, rl_nxt;

  // ---------------- memories ----------------
  logic [6:0] stk_mem [dto_pkg::SLOTS];
  logic [6:0] gp_mem  [dto_pkg::SLOTS];
  logic [5:0] gl_mem  [dto_pkg::SLOTS];
  logic [6:0] hp_mem  [dto_pkg::SLOTS];
  logic [5:0] hl_mem  [dto_pkg::SLOTS];
  logic [dto_pkg::SLOTS-1:0] pv_r;     // head/tag entry assigned since begin

  logic       stk_we;
  logic [6:0] stk_wa, stk_wd, stk_ra, stk_q;
  logic       gm_we;
  logic [6:0] gm_wa, gm_wp, gm_ra, gp_q;
  logic [5:0] gm_wl, gl_q;
  logic       hm_we;
  logic [6:0] hm_wa, hm_wp, hm_ra, hp_q;
  logic [5:0] hm_wl, hl_q;
  logic       pv_clr;

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (gm_we) begin
      gp_mem[gm_wa] <= gm_wp;
      gl_mem[gm_wa] <= gm_wl;
    end
    gp_q <= gp_mem[gm_ra];
    gl_q <= gl_mem[gm_ra];
  end

  always_ff @(posedge clk) begin
    if (hm_we) begin
      hp_mem[hm_wa] <= hm_wp;
      hl_mem[hm_wa] <= hm_wl;
    end
    hp_q <= pv_r[hm_ra] ? hp_mem[hm_ra] : dto_pkg::NO_PARENT;
    hl_q <= pv_r[hm_ra] ? hl_mem[hm_ra] : dto_pkg::NO_LABEL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || pv_clr) pv_r <= '0;
    else if (hm_we) pv_r[hm_wa] <= 1'b1;
  end

  // ---------------- termination and valid transitions ----------------
  logic       done;
  logic [3:0] mask;

  always_comb begin
    if (!sys_r) begin
      done    = (sp_r <= 7'd1) && (pos_r >= n);
      mask[0] = pos_r <= n;
      mask[1] = sp_r >= 7'd2;
      mask[2] = (sp_r >= 7'd1) && (top_r != 7'd0) && (pos_r <= n);
      mask[3] = 1'b0;
    end else begin
      done = (sp_r == 7'd0) && (pos_r >= n);
      mask = 4'hF;
      if (pos_r >= n) mask[1:0] = 2'b00;
      if (sp_r == 7'd0) mask[3:1] = 3'b000;
      else begin
        if ((pos_r <= np1) && (hpl_r == dto_pkg::NO_PARENT)) mask[3] = 1'b0;
        if (hpl_r != dto_pkg::NO_PARENT) mask[2] = 1'b0;
        if ((pos_r <= n) && (hpi_r != dto_pkg::NO_PARENT)) mask[1] = 1'b0;
      end
    end
  end

  // ---------------- output register ----------------
  logic out_load;

  assign in_ready = (state_r == dto_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_position    <= pos_r;
      out_depth       <= sp_r;
      out_valid_mask  <= mask_r;
      out_cost_shift  <= c0_r;
      out_cost_right  <= c1_r;
      out_cost_left   <= c2_r;
      out_cost_reduce <= c3_r;
      out_step_loss   <= loss_r;
      out_done_res    <= done;
      out_status      <= status_r;
      out_read_parent <= rp_r;
      out_read_label  <= rl_r;
    end
  end

  // ---------------- sequencer ----------------
  logic [6:0] buf_end;
  logic [6:0] hd_left;
  logic [1:0] inc0, inc1, inc2, inc3;

  assign buf_end = sys_r ? np1 : n;
  assign hd_left = (sys_r && (pos_r > n)) ? 7'd0 : pos_r;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    act_nxt    = act_r;
    word_nxt   = word_r;
    gpar_nxt   = gpar_r;
    glab_nxt   = glab_r;
    tr_nxt     = tr_r;
    alab_nxt   = alab_r;
    sp_nxt     = sp_r;
    pos_nxt    = pos_r;
    top_nxt    = top_r;
    second_nxt = second_r;
    gpl_nxt    = gpl_r;
    gll_nxt    = gll_r;
    hpl_nxt    = hpl_r;
    gpi_nxt    = gpi_r;
    gli_nxt    = gli_r;
    hpi_nxt    = hpi_r;
    s_nxt      = s_r;
    t_nxt      = t_r;
    si_nxt     = si_r;
    scnt_nxt   = scnt_r;
    bi_nxt     = bi_r;
    c0_nxt     = c0_r;
    c1_nxt     = c1_r;
    c2_nxt     = c2_r;
    c3_nxt     = c3_r;
    mask_nxt   = mask_r;
    loss_nxt   = loss_r;
    status_nxt = status_r;
    rp_nxt     = rp_r;
    rl_nxt     = rl_r;
    inc0 = 2'd0; inc1 = 2'd0; inc2 = 2'd0; inc3 = 2'd0;
    stk_we = 1'b0; stk_wa = 7'd0; stk_wd = 7'd0; stk_ra = 7'd0;
    gm_we = 1'b0; gm_wa = 7'd0; gm_wp = 7'd0; gm_wl = 6'd0; gm_ra = 7'd0;
    hm_we = 1'b0; hm_wa = 7'd0; hm_wp = 7'd0; hm_wl = 6'd0; hm_ra = 7'd0;
    pv_clr = 1'b0;
    out_load = 1'b0;

    unique case (state_r)
      dto_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          word_nxt   = in_word;
          gpar_nxt   = in_gold_parent;
          glab_nxt   = in_gold_label;
          tr_nxt     = in_transition;
          alab_nxt   = in_arc_label;
          loss_nxt   = 2'd0;
          status_nxt = dto_pkg::ST_OK;
          rp_nxt     = 7'd0;
          rl_nxt     = 6'd0;
          phase_nxt  = 1'b1;
          unique case (in_action)
            dto_pkg::ACT_LOAD:  state_nxt = dto_pkg::S_LOAD;
            dto_pkg::ACT_BEGIN: state_nxt = dto_pkg::S_BEGIN;
            dto_pkg::ACT_TRANS: begin
              phase_nxt = 1'b0;
              state_nxt = dto_pkg::S_CTX_A;
            end
            dto_pkg::ACT_READ:  state_nxt = dto_pkg::S_READ_A;
            default:            state_nxt = dto_pkg::S_IDLE;
          endcase
        end
      end

      dto_pkg::S_LOAD: begin
        if ((word_r == 7'd0) || (word_r > MAXW_W)) status_nxt = dto_pkg::ST_BAD_INDEX;
        else begin
          gm_we = 1'b1;
          gm_wa = word_r;
          gm_wp = gpar_r;
          gm_wl = glab_r;
          if (glab_r > label_count_r) status_nxt = dto_pkg::ST_LABEL_BIG;
        end
        state_nxt = dto_pkg::S_CTX_A;
      end

      dto_pkg::S_READ_A: begin
        hm_ra     = (word_r < SLOTS_W) ? word_r : 7'd0;
        state_nxt = dto_pkg::S_READ_B;
      end

      dto_pkg::S_READ_B: begin
        if (word_r >= SLOTS_W) status_nxt = dto_pkg::ST_BAD_INDEX;
        else begin
          rp_nxt = hp_q;
          rl_nxt = hl_q;
        end
        state_nxt = dto_pkg::S_CTX_A;
      end

      dto_pkg::S_BEGIN: begin
        gm_we  = 1'b1;
        pv_clr = 1'b1;
        stk_we = 1'b1;
        sp_nxt = 7'd1;
        if (!sys_r && (root_tag_r == 6'd0)) begin
          stk_wd  = 7'd0;
          pos_nxt = 7'd1;
        end else begin
          stk_wd  = 7'd1;
          pos_nxt = 7'd2;
        end
        state_nxt = dto_pkg::S_FIN_A;
      end

      // fetch stack top, second, and the heads of top and buffer front
      dto_pkg::S_CTX_A: begin
        stk_ra    = (sp_r != 7'd0) ? sp_r - 7'd1 : 7'd0;
        state_nxt = dto_pkg::S_CTX_B;
      end

      dto_pkg::S_CTX_B: begin
        top_nxt   = (sp_r != 7'd0) ? stk_q : 7'd0;
        stk_ra    = (sp_r >= 7'd2) ? sp_r - 7'd2 : 7'd0;
        state_nxt = dto_pkg::S_CTX_C;
      end

      dto_pkg::S_CTX_C: begin
        second_nxt = (sp_r >= 7'd2) ? stk_q : 7'd0;
        gm_ra      = top_r;
        hm_ra      = top_r;
        state_nxt  = dto_pkg::S_CTX_D;
      end

      dto_pkg::S_CTX_D: begin
        gpl_nxt   = gp_q;
        gll_nxt   = gl_q;
        hpl_nxt   = hp_q;
        gm_ra     = pos_r;
        hm_ra     = pos_r;
        state_nxt = dto_pkg::S_CTX_E;
      end

      dto_pkg::S_CTX_E: begin
        gpi_nxt   = gp_q;
        gli_nxt   = gl_q;
        hpi_nxt   = hp_q;
        stk_ra    = 7'd0;
        state_nxt = phase_r ? dto_pkg::S_EVAL : dto_pkg::S_TRANS;
      end

      dto_pkg::S_TRANS: begin
        if (done || !mask[tr_r]) begin
          status_nxt = dto_pkg::ST_NOT_APPL;
          phase_nxt  = 1'b1;
          state_nxt  = dto_pkg::S_CTX_A;
        end else begin
          unique case (tr_r)
            dto_pkg::TR_SHIFT: begin
              if (sp_r < SLOTS_W) begin
                stk_we = 1'b1;
                stk_wa = sp_r;
                stk_wd = pos_r;
                sp_nxt = sp_r + 7'd1;
              end
              pos_nxt = pos_r + 7'd1;
            end
            dto_pkg::TR_RIGHT: begin
              hm_we = 1'b1;
              hm_wl = alab_r;
              if (!sys_r) begin
                hm_wa    = top_r;
                hm_wp    = second_r;
                loss_nxt = dto_pkg::arc_loss(gpl_r, gll_r, second_r, alab_r);
                sp_nxt   = sp_r - 7'd1;
              end else begin
                if (sp_r < SLOTS_W) begin
                  stk_we = 1'b1;
                  stk_wa = sp_r;
                  stk_wd = pos_r;
                  sp_nxt = sp_r + 7'd1;
                end
                hm_wa    = pos_r;
                hm_wp    = top_r;
                loss_nxt = dto_pkg::arc_loss(gpi_r, gli_r, top_r, alab_r);
                pos_nxt  = pos_r + 7'd1;
              end
            end
            dto_pkg::TR_LEFT: begin
              hm_we    = 1'b1;
              hm_wa    = top_r;
              hm_wp    = hd_left;
              hm_wl    = alab_r;
              loss_nxt = dto_pkg::arc_loss(gpl_r, gll_r, hd_left, alab_r);
              sp_nxt   = sp_r - 7'd1;
            end
            dto_pkg::TR_REDUCE: sp_nxt = sp_r - 7'd1;
            default:            sp_nxt = sp_r;
          endcase
          state_nxt = dto_pkg::S_FIN_A;
        end
      end

      // root attachment of the last arc-hybrid stack word
      dto_pkg::S_FIN_A: begin
        stk_ra    = 7'd0;
        state_nxt = dto_pkg::S_FIN_B;
      end

      dto_pkg::S_FIN_B: begin
        t_nxt     = stk_q;
        gm_ra     = (stk_q < SLOTS_W) ? stk_q : 7'd0;
        state_nxt = dto_pkg::S_FIN_C;
      end

      dto_pkg::S_FIN_C: begin
        if (!sys_r && done && (sp_r == 7'd1) && (t_r < SLOTS_W)) begin
          hm_we = 1'b1;
          hm_wa = t_r;
          hm_wp = 7'd0;
          hm_wl = root_tag_r;
          if (gp_q != 7'd0) loss_nxt = loss_r + 2'd1;
        end
        phase_nxt = 1'b1;
        state_nxt = dto_pkg::S_CTX_A;
      end

      dto_pkg::S_EVAL: begin
        c0_nxt = 8'd0; c1_nxt = 8'd0; c2_nxt = 8'd0; c3_nxt = 8'd0;
        si_nxt = 7'd0;
        if (done) begin
          mask_nxt  = 4'd0;
          state_nxt = dto_pkg::S_PUT;
        end else begin
          mask_nxt = mask;
          if (!sys_r) begin
            c0_nxt   = {7'd0, (sp_r != 7'd0) && (gpl_r == pos_r)};
            c1_nxt   = {7'd0, gpl_r >= pos_r};
            c2_nxt   = {7'd0, (sp_r != 7'd0) && (pos_r <= n) && (gpi_r == top_r)}
                     + {7'd0, (sp_r >= 7'd2) && (gpl_r == second_r)};
            scnt_nxt = (sp_r != 7'd0) ? sp_r - 7'd1 : 7'd0;
          end else begin
            c1_nxt   = {7'd0, (gpi_r > pos_r) ||
                               ((gpi_r == 7'd0) && (sp_r != 7'd0) && (stk_q != 7'd0))};
            scnt_nxt = sp_r;
          end
          state_nxt = dto_pkg::S_SCAN_A;
        end
      end

      // stack walk
      dto_pkg::S_SCAN_A: begin
        if (si_r >= scnt_r) begin
          bi_nxt    = pos_r;
          state_nxt = dto_pkg::S_BUF_A;
        end else begin
          stk_ra    = si_r;
          state_nxt = dto_pkg::S_SCAN_B;
        end
      end

      dto_pkg::S_SCAN_B: begin
        s_nxt     = stk_q;
        gm_ra     = stk_q;
        hm_ra     = stk_q;
        state_nxt = dto_pkg::S_SCAN_C;
      end

      dto_pkg::S_SCAN_C: begin
        if (!sys_r) begin
          inc0 = {1'b0, (pos_r <= n) && ((gp_q == pos_r) || (gpi_r == s_r))};
        end else begin
          if ((gp_q == pos_r) && (hp_q == dto_pkg::NO_PARENT)) begin
            inc0 = 2'd1;
            inc1 = 2'd1;
          end
          if ((pos_r <= n) && (gpi_r == s_r)) begin
            inc0 = inc0 + {1'b0, s_r != 7'd0};
            inc1 = inc1 + {1'b0, s_r != top_r};
          end
        end
        c0_nxt    = dto_pkg::sat_add(c0_r, inc0);
        c1_nxt    = dto_pkg::sat_add(c1_r, inc1);
        si_nxt    = si_r + 7'd1;
        state_nxt = dto_pkg::S_SCAN_A;
      end

      // remaining buffer walk
      dto_pkg::S_BUF_A: begin
        if (bi_r > buf_end) state_nxt = dto_pkg::S_PUT;
        else begin
          gm_ra     = bi_r;
          state_nxt = dto_pkg::S_BUF_B;
        end
      end

      dto_pkg::S_BUF_B: begin
        if (!sys_r) begin
          inc1 = {1'b0, gp_q == top_r};
          inc2 = {1'b0, (bi_r != pos_r) && ((gp_q == top_r) || (gpl_r == bi_r))};
        end else begin
          if ((bi_r <= n) && (gp_q == top_r)) begin
            inc3 = 2'd1;
            inc2 = 2'd1;
          end
          inc2 = inc2 + {1'b0, (bi_r != pos_r) && (gpl_r == bi_r)};
        end
        c1_nxt    = dto_pkg::sat_add(c1_r, inc1);
        c2_nxt    = dto_pkg::sat_add(c2_r, inc2);
        c3_nxt    = dto_pkg::sat_add(c3_r, inc3);
        bi_nxt    = bi_r + 7'd1;
        state_nxt = dto_pkg::S_BUF_A;
      end

      dto_pkg::S_PUT: begin
        if (!out_valid || out_ready) begin
          out_load  = 1'b1;
          state_nxt = dto_pkg::S_IDLE;
        end
      end

      default: state_nxt = dto_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dto_pkg::S_IDLE;
      sp_r    <= 7'd0;
      pos_r   <= 7'd0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    word_r   <= word_nxt;
    gpar_r   <= gpar_nxt;
    glab_r   <= glab_nxt;
    tr_r     <= tr_nxt;
    alab_r   <= alab_nxt;
    top_r    <= top_nxt;
    second_r <= second_nxt;
    gpl_r    <= gpl_nxt;
    gll_r    <= gll_nxt;
    hpl_r    <= hpl_nxt;
    gpi_r    <= gpi_nxt;
    gli_r    <= gli_nxt;
    hpi_r    <= hpi_nxt;
    s_r      <= s_nxt;
    t_r      <= t_nxt;
    si_r     <= si_nxt;
    scnt_r   <= scnt_nxt;
    bi_r     <= bi_nxt;
    c0_r     <= c0_nxt;
    c1_r     <= c1_nxt;
    c2_r     <= c2_nxt;
    c3_r     <= c3_nxt;
    mask_r   <= mask_nxt;
    loss_r   <= loss_nxt;
    status_r <= status_nxt;
    rp_r     <= rp_nxt;
    rl_r     <= rl_nxt;
  end

  // action code kept for visibility in waveforms; begin writes gold entry 0
  logic unused_act;
  assign unused_act = ^act_r;

endmodule
